// ----- hdl/qme_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quadratic map
// escape iteration block. Used by the controller, datapath and top level.
package qme_pkg;

    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int LEVEL_W = 18;
    localparam int MAXI_W  = 16;
    localparam int RAD_W   = 31;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LAMBDA_RE = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LAMBDA_IM = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_RE = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_IM = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RADIUS_SQ = 3'd4;
    localparam logic [IDX_W-1:0] CFG_MAX_ITER  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_UNIT_MODE = 3'd6;

    // Fixed-point constants (Q7.24 values, Q.48 escape bound)
    localparam logic signed [31:0] ONE_Q24    = 32'sd16777216;
    localparam logic signed [63:0] HALF_Q24   = 64'sd8388608;
    localparam logic [63:0]        ESCAPE_Q48 = 64'd100 << 48;
    localparam logic [15:0]        MAX_ITER_RESET = 16'd500;

    // Operand selection of the shared complex multiply unit
    typedef enum logic [1:0] {
        OP_SQ,
        OP_M1,
        OP_M2
    } qme_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ,
        ST_EVAL,
        ST_C1,
        ST_M2,
        ST_C2,
        ST_DONE
    } qme_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    prep;
        logic    mul_en;
        qme_op_t mul_op;
        logic    wr_t;
        logic    wr_x;
    } qme_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic esc;
        logic ins;
    } qme_stat_t;

    // Round a Q.48 product to Q.24: add half, floor
    function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + HALF_Q24;
        return s[63:24];
    endfunction

    // Saturate to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -41'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/qme_point_if.sv -----
// Input channel of the escape iteration block: one start point per beat.
// Depends on nothing.
interface qme_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;

    modport source (output valid, output start_re, output start_im, input ready);
    modport sink   (input valid, input start_re, input start_im, output ready);
endinterface

// ----- hdl/qme_result_if.sv -----
// Output channel of the escape iteration block: one hit/level pair per beat.
// Depends on qme_pkg for the level width.
interface qme_result_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [qme_pkg::LEVEL_W-1:0]  level;

    modport source (output valid, output hit, output level, input ready);
    modport sink   (input valid, input hit, input level, output ready);
endinterface

// ----- hdl/qme_datapath.sv -----
// Datapath: iterate register, four-multiplier complex unit, combine stage
// and the escape / disk tests. Depends on qme_pkg.
module qme_datapath
(
    input  logic                          clk,
    input  qme_pkg::qme_cmd_t             cmd,
    input  logic signed [31:0]            start_re,
    input  logic signed [31:0]            start_im,
    input  logic signed [31:0]            lambda_re,
    input  logic signed [31:0]            lambda_im,
    input  logic signed [31:0]            center_re,
    input  logic signed [31:0]            center_im,
    input  logic [qme_pkg::RAD_W-1:0]     radius_sq,
    output qme_pkg::qme_stat_t            stat
);

    logic signed [31:0] xr_reg, xi_reg;
    logic signed [31:0] tr_reg, ti_reg;
    logic signed [31:0] wr_reg, wr_next;
    logic signed [31:0] dr_reg, di_reg;
    logic               dok_reg, dok_next;
    logic signed [63:0] p_reg [4];

    logic signed [32:0] wsum;
    logic signed [32:0] dr33, di33;
    logic signed [31:0] ma [4];
    logic signed [31:0] mb [4];
    logic signed [40:0] re_sum, im_sum;
    logic signed [31:0] c_re, c_im;
    logic [63:0]        esc_sum, dsq_sum;

    // Prepare w = 1 + x and the offset from the disk center
    always_comb
    begin
        wsum    = 33'(xr_reg) + 33'(qme_pkg::ONE_Q24);
        wr_next = qme_pkg::sat32(41'(wsum));
        dr33    = 33'(xr_reg) - 33'(center_re);
        di33    = 33'(xi_reg) - 33'(center_im);
        dok_next = (dr33[32] == dr33[31]) && !(dr33[31] && (dr33[30:0] == '0))
                && (di33[32] == di33[31]) && !(di33[31] && (di33[30:0] == '0));
    end

    // Select multiplier operands for the current pass
    always_comb
    begin
        case (cmd.mul_op)
            qme_pkg::OP_SQ:
            begin
                ma[0] = xr_reg;    mb[0] = xr_reg;
                ma[1] = xi_reg;    mb[1] = xi_reg;
                ma[2] = dr_reg;    mb[2] = dr_reg;
                ma[3] = di_reg;    mb[3] = di_reg;
            end
            qme_pkg::OP_M1:
            begin
                ma[0] = xr_reg;    mb[0] = wr_reg;
                ma[1] = xi_reg;    mb[1] = xi_reg;
                ma[2] = xr_reg;    mb[2] = xi_reg;
                ma[3] = xi_reg;    mb[3] = wr_reg;
            end
            qme_pkg::OP_M2:
            begin
                ma[0] = lambda_re; mb[0] = tr_reg;
                ma[1] = lambda_im; mb[1] = ti_reg;
                ma[2] = lambda_re; mb[2] = ti_reg;
                ma[3] = lambda_im; mb[3] = tr_reg;
            end
            default:
            begin
                ma[0] = xr_reg;    mb[0] = xr_reg;
                ma[1] = xi_reg;    mb[1] = xi_reg;
                ma[2] = dr_reg;    mb[2] = dr_reg;
                ma[3] = di_reg;    mb[3] = di_reg;
            end
        endcase
    end

    // Combine rounded products into a saturated complex result
    always_comb
    begin
        re_sum = 41'(qme_pkg::rnd24(p_reg[0])) - 41'(qme_pkg::rnd24(p_reg[1]));
        im_sum = 41'(qme_pkg::rnd24(p_reg[2])) + 41'(qme_pkg::rnd24(p_reg[3]));
        c_re   = qme_pkg::sat32(re_sum);
        c_im   = qme_pkg::sat32(im_sum);
    end

    // Escape and disk tests from the squared terms
    always_comb
    begin
        esc_sum  = $unsigned(p_reg[0]) + $unsigned(p_reg[1]);
        dsq_sum  = $unsigned(p_reg[2]) + $unsigned(p_reg[3]);
        stat.esc = (esc_sum >= qme_pkg::ESCAPE_Q48);
        stat.ins = dok_reg && (dsq_sum < 64'({radius_sq, 24'b0}));
    end

    // Hold the iterate, load a new start or take the advanced value
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xr_reg <= start_re;
            xi_reg <= start_im;
        end
        else if (cmd.wr_x)
        begin
            xr_reg <= c_re;
            xi_reg <= c_im;
        end
        if (cmd.wr_t)
        begin
            tr_reg <= c_re;
            ti_reg <= c_im;
        end
        if (cmd.prep)
        begin
            wr_reg  <= wr_next;
            dr_reg  <= dr33[31:0];
            di_reg  <= di33[31:0];
            dok_reg <= dok_next;
        end
    end

    // Four products per pass, registered
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k] <= ma[k] * mb[k];
            end
        end
    end

endmodule

// ----- hdl/qme_ctrl.sv -----
// Controller: sequences test and multiply passes, counts iterations,
// applies the stop rules and drives both handshakes. Depends on qme_pkg.
module qme_ctrl
#(
    parameter int ITER_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pt_valid,
    output logic                          pt_ready,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_hit,
    output logic [qme_pkg::LEVEL_W-1:0]   res_level,
    input  logic [qme_pkg::MAXI_W-1:0]    max_iter,
    input  logic                          unit_mode,
    input  qme_pkg::qme_stat_t            stat,
    output qme_pkg::qme_cmd_t             cmd
);

    localparam int MI_W  = (ITER_WIDTH > qme_pkg::MAXI_W) ? ITER_WIDTH : qme_pkg::MAXI_W;
    localparam int LVL_W = (ITER_WIDTH + 2 > qme_pkg::LEVEL_W) ? ITER_WIDTH + 2
                                                                : qme_pkg::LEVEL_W;

    qme_pkg::qme_state_t      state_reg, state_next;
    logic [ITER_WIDTH-1:0]    cnt_reg, cnt_next;
    logic                     was_reg, was_next;
    logic                     start_in_reg, start_in_next;
    logic                     seen_reg, seen_next;
    logic                     hit_reg, hit_next;
    logic                     res_valid_reg, res_valid_next;
    logic                     res_hit_reg, res_hit_next;
    logic [qme_pkg::LEVEL_W-1:0] res_level_reg, res_level_next;

    logic [MI_W-1:0]          mi_ext;
    logic [ITER_WIDTH-1:0]    lim;
    logic                     below;
    logic                     first;
    logic                     sin;
    logic                     seen;
    logic                     cont;
    logic                     hit_eval;
    logic                     accept;
    logic                     out_free;
    logic [LVL_W-1:0]         lvl;

    // Stop rules evaluated on the current iterate
    always_comb
    begin
        mi_ext   = MI_W'(max_iter);
        lim      = mi_ext[ITER_WIDTH-1:0];
        below    = (cnt_reg < lim);
        first    = (cnt_reg == '0);
        sin      = first ? stat.ins : start_in_reg;
        seen     = seen_reg | (!first && !stat.ins);
        if (unit_mode)
        begin
            cont     = below && !stat.esc && !sin;
            hit_eval = below && seen;
        end
        else
        begin
            cont     = below && !stat.esc && (!was_reg || stat.ins);
            hit_eval = below && was_reg;
        end
        accept   = pt_valid && (state_reg == qme_pkg::ST_IDLE);
        out_free = !res_valid_reg || res_ready;
        lvl      = LVL_W'(cnt_reg) + (LVL_W'(cnt_reg) << 1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qme_pkg::ST_IDLE: if (pt_valid) state_next = qme_pkg::ST_PREP;
            qme_pkg::ST_PREP: state_next = qme_pkg::ST_SQ;
            qme_pkg::ST_SQ:   state_next = qme_pkg::ST_EVAL;
            qme_pkg::ST_EVAL: state_next = cont ? qme_pkg::ST_C1 : qme_pkg::ST_DONE;
            qme_pkg::ST_C1:   state_next = qme_pkg::ST_M2;
            qme_pkg::ST_M2:   state_next = qme_pkg::ST_C2;
            qme_pkg::ST_C2:   state_next = qme_pkg::ST_PREP;
            qme_pkg::ST_DONE: if (out_free) state_next = qme_pkg::ST_IDLE;
            default:          state_next = qme_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands and input ready
    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = qme_pkg::OP_SQ;
        pt_ready   = 1'b0;
        case (state_reg)
            qme_pkg::ST_IDLE:
            begin
                pt_ready = 1'b1;
                cmd.load = pt_valid;
            end
            qme_pkg::ST_PREP: cmd.prep = 1'b1;
            qme_pkg::ST_SQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = qme_pkg::OP_SQ;
            end
            qme_pkg::ST_EVAL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = qme_pkg::OP_M1;
            end
            qme_pkg::ST_C1: cmd.wr_t = 1'b1;
            qme_pkg::ST_M2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = qme_pkg::OP_M2;
            end
            qme_pkg::ST_C2: cmd.wr_x = 1'b1;
            default: ;
        endcase
    end

    // Iteration bookkeeping and output register
    always_comb
    begin
        cnt_next       = cnt_reg;
        was_next       = was_reg;
        start_in_next  = start_in_reg;
        seen_next      = seen_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg;
        res_hit_next   = res_hit_reg;
        res_level_next = res_level_reg;
        if (accept)
        begin
            cnt_next      = '0;
            was_next      = 1'b0;
            start_in_next = 1'b0;
            seen_next     = 1'b0;
        end
        if (state_reg == qme_pkg::ST_EVAL)
        begin
            start_in_next = sin;
            seen_next     = seen;
            hit_next      = hit_eval;
            if (cont)
            begin
                was_next = stat.ins;
                cnt_next = cnt_reg + ITER_WIDTH'(1);
            end
        end
        // Drop the result beat once taken, load a new one when the slot frees
        if (res_ready)
            res_valid_next = 1'b0;
        if ((state_reg == qme_pkg::ST_DONE) && out_free)
        begin
            res_valid_next = 1'b1;
            res_hit_next   = hit_reg;
            res_level_next = hit_reg ? lvl[qme_pkg::LEVEL_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qme_pkg::ST_IDLE;
            cnt_reg       <= '0;
            was_reg       <= 1'b0;
            start_in_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            was_reg       <= was_next;
            start_in_reg  <= start_in_next;
            seen_reg      <= seen_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hit_reg   <= res_hit_next;
        res_level_reg <= res_level_next;
    end

    assign res_valid = res_valid_reg;
    assign res_hit   = res_hit_reg;
    assign res_level = res_level_reg;

endmodule

// ----- hdl/quadratic_map_escape_iteration.sv -----
// Escape iteration of x <- lambda*x*(1+x): a point runs up to max_iter iterations,
// and the next point is taken only once the result of the last one is loaded into
// the result register, so the block never works on two points at once.
// Each iteration is a test pass and two passes of the shared four-multiplier
// complex unit. Reset (rst_n low, asynchronous) returns the controller to idle,
// empties the result register and restores the configuration reset values.
module quadratic_map_escape_iteration
#(
    parameter int ITER_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    qme_point_if.sink                      point,
    qme_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [qme_pkg::IDX_W-1:0]      cfg_index,
    input  logic [qme_pkg::CFG_W-1:0]      cfg_data
);

    logic signed [31:0]             lambda_re_reg, lambda_im_reg;
    logic signed [31:0]             center_re_reg, center_im_reg;
    logic [qme_pkg::RAD_W-1:0]      radius_sq_reg;
    logic [qme_pkg::MAXI_W-1:0]     max_iter_reg;
    logic                           unit_mode_reg;

    qme_pkg::qme_cmd_t              cmd;
    qme_pkg::qme_stat_t             stat;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_re_reg <= qme_pkg::ONE_Q24;
            lambda_im_reg <= '0;
            center_re_reg <= '0;
            center_im_reg <= '0;
            radius_sq_reg <= '0;
            max_iter_reg  <= qme_pkg::MAX_ITER_RESET;
            unit_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qme_pkg::CFG_LAMBDA_RE: lambda_re_reg <= cfg_data;
                qme_pkg::CFG_LAMBDA_IM: lambda_im_reg <= cfg_data;
                qme_pkg::CFG_CENTER_RE: center_re_reg <= cfg_data;
                qme_pkg::CFG_CENTER_IM: center_im_reg <= cfg_data;
                qme_pkg::CFG_RADIUS_SQ: radius_sq_reg <= cfg_data[qme_pkg::RAD_W-1:0];
                qme_pkg::CFG_MAX_ITER:  max_iter_reg  <= cfg_data[qme_pkg::MAXI_W-1:0];
                qme_pkg::CFG_UNIT_MODE: unit_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    qme_ctrl #(
        .ITER_WIDTH (ITER_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (point.valid),
        .pt_ready  (point.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_hit   (result.hit),
        .res_level (result.level),
        .max_iter  (max_iter_reg),
        .unit_mode (unit_mode_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    qme_datapath u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .start_re  (point.start_re),
        .start_im  (point.start_im),
        .lambda_re (lambda_re_reg),
        .lambda_im (lambda_im_reg),
        .center_re (center_re_reg),
        .center_im (center_im_reg),
        .radius_sq (radius_sq_reg),
        .stat      (stat)
    );

endmodule

// ----- hdl/qme_checker.sv -----
// Port-level checks for the escape iteration block, bound to the top level.
// Depends on qme_pkg and quadratic_map_escape_iteration.
module qme_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pt_valid,
    input logic                          pt_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          res_hit,
    input logic [qme_pkg::LEVEL_W-1:0]   res_level
);

    // A waiting result beat holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_hit) && $stable(res_level))
        else $error("result beat changed while stalled");

    // No color carries a zero level
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_hit |-> res_level == '0)
        else $error("level set on a no-color result");

    // A hit needs at least one iteration
    a_hit_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_hit |-> res_level != '0)
        else $error("hit with zero level");

    // Block goes busy right after taking a point
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_ready |=> !pt_ready)
        else $error("second point taken while busy");

    // Result channel is empty once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind quadratic_map_escape_iteration qme_checker u_qme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (point.valid),
    .pt_ready  (point.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_hit   (result.hit),
    .res_level (result.level)
);
